// ===== sv/orthonormal_frame_from_up_forward_unit_macros.svh =====
// Assertion macros for the orthonormal frame unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef ORTHONORMAL_FRAME_FROM_UP_FORWARD_UNIT_MACROS_SVH
`define ORTHONORMAL_FRAME_FROM_UP_FORWARD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OFUF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ofuf: assertion failed");
`define OFUF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ofuf: assertion failed");
`else
`define OFUF_ASSERT(lbl, clk, rstn, prop)
`define OFUF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/ofuf_pkg.sv =====
// Shared types and constants for the orthonormal frame unit.
// No dependencies.
package ofuf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 12;
  localparam int unsigned IN_W = 16;
  localparam int unsigned OUT_W = 32;

  typedef logic signed [OUT_W-1:0] comp_t;
  typedef comp_t [2:0] vec3_t;

  typedef struct packed {
    logic signed [IN_W-1:0] up_in_x;
    logic signed [IN_W-1:0] up_in_y;
    logic signed [IN_W-1:0] up_in_z;
    logic signed [IN_W-1:0] fwd_in_x;
    logic signed [IN_W-1:0] fwd_in_y;
    logic signed [IN_W-1:0] fwd_in_z;
    logic                   do_normalize;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] up_out_x;
    logic signed [OUT_W-1:0] up_out_y;
    logic signed [OUT_W-1:0] up_out_z;
    logic signed [OUT_W-1:0] fwd_out_x;
    logic signed [OUT_W-1:0] fwd_out_y;
    logic signed [OUT_W-1:0] fwd_out_z;
  } out_t;

endpackage

// ===== sv/ofuf_norm.sv =====
// Pipelined unit-length scaling of one three-component vector.
// Depends on ofuf_pkg; stage enables come from the top level.
module ofuf_norm #(
  parameter int unsigned FracBits = ofuf_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [FracBits+3:0]     en_i,
  input  ofuf_pkg::vec3_t         vec_i,
  input  logic                    norm_i,
  output ofuf_pkg::vec3_t         vec_o
);

  localparam int unsigned NumDig = FracBits + 1;
  localparam int unsigned W = 2 * FracBits + 70;
  localparam int unsigned SW = 66;
  localparam int unsigned CW = ofuf_pkg::OUT_W;

  logic [2*CW-1:0] sq_q [3];
  logic [2:0]      neg0_q;
  ofuf_pkg::vec3_t raw0_q;
  logic            norm0_q;

  logic signed [W-1:0] r_q [NumDig+1][3];
  logic signed [W-1:0] p_q [NumDig+1][3];
  logic [FracBits:0]   q_q [NumDig+1][3];
  logic [SW-1:0]       s_q [NumDig+1];
  logic [2:0]          neg_q [NumDig+1];
  ofuf_pkg::vec3_t     raw_q [NumDig+1];
  logic                norm_q [NumDig+1];
  logic                zero_q [NumDig+1];

  logic [CW-1:0] mag [3];
  logic [SW-1:0] s_d;
  ofuf_pkg::vec3_t out_d;
  ofuf_pkg::vec3_t out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][CW-1] ? CW'(-vec_i[i]) : CW'(vec_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]   <= (2*CW)'(mag[i]) * (2*CW)'(mag[i]);
        neg0_q[i] <= vec_i[i][CW-1];
      end
      raw0_q  <= vec_i;
      norm0_q <= norm_i;
    end
  end

  assign s_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        r_q[0][i] <= (signed'(W'(sq_q[i])) <<< (2 * FracBits + 2)) - signed'(W'(s_d));
        p_q[0][i] <= -signed'(W'(s_d));
        q_q[0][i] <= '0;
      end
      s_q[0]    <= s_d;
      neg_q[0]  <= neg0_q;
      raw_q[0]  <= raw0_q;
      norm_q[0] <= norm0_q;
      zero_q[0] <= (s_d == '0);
    end
  end

  for (genvar j = 1; j <= NumDig; j++) begin : g_dig
    localparam int unsigned Bit = FracBits + 1 - j;
    logic signed [W-1:0] s_w;
    logic signed [W-1:0] trial [3];
    logic [2:0]          take;

    always_comb begin
      s_w = signed'(W'(s_q[j-1]));
      for (int i = 0; i < 3; i++) begin
        trial[i] = r_q[j-1][i] - (p_q[j-1][i] <<< (Bit + 2)) - (s_w <<< (2 * Bit + 2));
        take[i]  = !trial[i][W-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j+1]) begin
        for (int i = 0; i < 3; i++) begin
          r_q[j][i]      <= take[i] ? trial[i] : r_q[j-1][i];
          p_q[j][i]      <= take[i] ? p_q[j-1][i] + (s_w <<< (Bit + 1)) : p_q[j-1][i];
          q_q[j][i]      <= q_q[j-1][i] | ((FracBits+1)'(take[i]) << Bit);
        end
        s_q[j]    <= s_q[j-1];
        neg_q[j]  <= neg_q[j-1];
        raw_q[j]  <= raw_q[j-1];
        norm_q[j] <= norm_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!norm_q[NumDig]) begin
        out_d[i] = raw_q[NumDig][i];
      end else if (zero_q[NumDig]) begin
        out_d[i] = '0;
      end else if (neg_q[NumDig][i]) begin
        out_d[i] = -signed'(CW'(q_q[NumDig][i]));
      end else begin
        out_d[i] = signed'(CW'(q_q[NumDig][i]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[FracBits+3]) begin
      out_q <= out_d;
    end
  end

  assign vec_o = out_q;

endmodule

// ===== sv/orthonormal_frame_from_up_forward_unit.sv =====
// Top level of the orthonormal frame unit: cross products and normalization.
// Depends on ofuf_pkg, ofuf_norm and the assertion macro header.
//
// The input channel takes one beat per item: an up vector, a forward vector
// and a normalize flag, all Q3.12 by default. The output channel gives one
// beat per item: right = up x forward, the new up = forward x right, and the
// forward vector, each scaled to unit length when the flag is set.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// One item can enter every cycle while the output is not stalled. The
// normalizer recovers one result bit per pipeline stage, which sets the
// depth.
// Each stage holds its data while the next one is full and stalled, so
// bubbles close up and the input is stalled only when every stage is full.
// Reset clears the valid bits of all stages; the data registers keep
// whatever they hold.
`include "orthonormal_frame_from_up_forward_unit_macros.svh"

module orthonormal_frame_from_up_forward_unit #(
  parameter int unsigned FracBits = ofuf_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  ofuf_pkg::in_t  data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output ofuf_pkg::out_t data_o
);

  localparam int unsigned NormStages = FracBits + 4;
  localparam int unsigned Depth = NormStages + 4;
  localparam int unsigned IW = ofuf_pkg::IN_W;
  localparam int unsigned CW = ofuf_pkg::OUT_W;
  localparam int unsigned PW = IW + CW;

  logic [Depth-1:0] valid_q, valid_d, en;

  logic signed [IW-1:0] up_v [3];
  logic signed [IW-1:0] fw_v [3];

  logic signed [2*IW-1:0] prod1_q [6];
  logic signed [IW-1:0]   fwd1_q [3];
  logic                   norm1_q;

  ofuf_pkg::vec3_t      rt2_q;
  logic signed [IW-1:0] fwd2_q [3];
  logic                 norm2_q;

  logic signed [PW-1:0] prod3_q [6];
  ofuf_pkg::vec3_t      rt3_q;
  logic signed [IW-1:0] fwd3_q [3];
  logic                 norm3_q;

  ofuf_pkg::vec3_t rt4_q, nu4_q, fw4_q;
  logic            norm4_q;

  ofuf_pkg::vec3_t rt_o, nu_o, fw_o;

  always_comb begin
    en[Depth-1] = !valid_q[Depth-1] || !stall_i;
    for (int k = Depth - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? valid_i : valid_q[0];
    for (int k = 1; k < Depth; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = valid_q[Depth-1];

  assign up_v[0] = data_i.up_in_x;
  assign up_v[1] = data_i.up_in_y;
  assign up_v[2] = data_i.up_in_z;
  assign fw_v[0] = data_i.fwd_in_x;
  assign fw_v[1] = data_i.fwd_in_y;
  assign fw_v[2] = data_i.fwd_in_z;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod1_q[0] <= (2*IW)'(up_v[1]) * (2*IW)'(fw_v[2]);
      prod1_q[1] <= (2*IW)'(up_v[2]) * (2*IW)'(fw_v[1]);
      prod1_q[2] <= (2*IW)'(up_v[2]) * (2*IW)'(fw_v[0]);
      prod1_q[3] <= (2*IW)'(up_v[0]) * (2*IW)'(fw_v[2]);
      prod1_q[4] <= (2*IW)'(up_v[0]) * (2*IW)'(fw_v[1]);
      prod1_q[5] <= (2*IW)'(up_v[1]) * (2*IW)'(fw_v[0]);
      fwd1_q     <= fw_v;
      norm1_q    <= data_i.do_normalize;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        rt2_q[i] <= CW'(prod1_q[2*i] >>> FracBits) - CW'(prod1_q[2*i+1] >>> FracBits);
      end
      fwd2_q  <= fwd1_q;
      norm2_q <= norm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      prod3_q[0] <= PW'(fwd2_q[1]) * PW'(rt2_q[2]);
      prod3_q[1] <= PW'(fwd2_q[2]) * PW'(rt2_q[1]);
      prod3_q[2] <= PW'(fwd2_q[2]) * PW'(rt2_q[0]);
      prod3_q[3] <= PW'(fwd2_q[0]) * PW'(rt2_q[2]);
      prod3_q[4] <= PW'(fwd2_q[0]) * PW'(rt2_q[1]);
      prod3_q[5] <= PW'(fwd2_q[1]) * PW'(rt2_q[0]);
      rt3_q      <= rt2_q;
      fwd3_q     <= fwd2_q;
      norm3_q    <= norm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        nu4_q[i] <= CW'(prod3_q[2*i] >>> FracBits) - CW'(prod3_q[2*i+1] >>> FracBits);
        fw4_q[i] <= CW'(fwd3_q[i]);
      end
      rt4_q   <= rt3_q;
      norm4_q <= norm3_q;
    end
  end

  ofuf_norm #(.FracBits(FracBits)) u_norm_rt (
    .clk_i  (clk_i),
    .en_i   (en[Depth-1:4]),
    .vec_i  (rt4_q),
    .norm_i (norm4_q),
    .vec_o  (rt_o)
  );

  ofuf_norm #(.FracBits(FracBits)) u_norm_nu (
    .clk_i  (clk_i),
    .en_i   (en[Depth-1:4]),
    .vec_i  (nu4_q),
    .norm_i (norm4_q),
    .vec_o  (nu_o)
  );

  ofuf_norm #(.FracBits(FracBits)) u_norm_fw (
    .clk_i  (clk_i),
    .en_i   (en[Depth-1:4]),
    .vec_i  (fw4_q),
    .norm_i (norm4_q),
    .vec_o  (fw_o)
  );

  assign data_o.right_x   = rt_o[0];
  assign data_o.right_y   = rt_o[1];
  assign data_o.right_z   = rt_o[2];
  assign data_o.up_out_x  = nu_o[0];
  assign data_o.up_out_y  = nu_o[1];
  assign data_o.up_out_z  = nu_o[2];
  assign data_o.fwd_out_x = fw_o[0];
  assign data_o.fwd_out_y = fw_o[1];
  assign data_o.fwd_out_z = fw_o[2];

  `OFUF_ASSERT(a_accept_fills_first, clk_i, rst_ni, (valid_i && !stall_o) |=> valid_q[0])
  `OFUF_ASSERT(a_stall_means_full, clk_i, rst_ni, stall_o |-> (&valid_q))
  `OFUF_ASSERT(a_empty_tail_accepts, clk_i, rst_ni, !valid_q[Depth-1] |-> !stall_o)
  `OFUF_ASSERT_ALWAYS(a_stall_needs_output, clk_i, stall_o |-> valid_o)

endmodule

// ===== tb/sv/orthonormal_frame_from_up_forward_unit_tb.sv =====
// Testbench for the orthonormal frame unit: drives up/forward beats, predicts
// each right/up/forward basis in the bench and compares every output beat.
// Depends on ofuf_pkg and the orthonormal_frame_from_up_forward_unit RTL.
`timescale 1ns / 100ps

module orthonormal_frame_from_up_forward_unit_tb;

  localparam int FB = ofuf_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = FB + 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  ofuf_pkg::in_t data_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  ofuf_pkg::out_t data_o;

  ofuf_pkg::out_t expected_frames[$];
  int errors = 0;
  int frames_seen = 0;
  int items_sent = 0;
  int normalized_sent = 0;
  bit out_idle_on = 1'b1;
  int hold_cycles = 0;

  orthonormal_frame_from_up_forward_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .data_i(data_i), .valid_o(valid_o), .stall_i(stall_i), .data_o(data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_shift(longint p);
    return p >>> FB;
  endfunction

  function automatic void cross_fx(input longint a[3], input longint b[3],
                                   output longint r[3]);
    r[0] = floor_shift(a[1] * b[2]) - floor_shift(a[2] * b[1]);
    r[1] = floor_shift(a[2] * b[0]) - floor_shift(a[0] * b[2]);
    r[2] = floor_shift(a[0] * b[1]) - floor_shift(a[1] * b[0]);
  endfunction

  // A trial bit t is kept when t <= 2^FB and (2t-1)^2 * S <= (2a)^2 * 2^(2*FB), done at 192 bits.
  function automatic void unit_scale(inout longint v[3]);
    logic [191:0] sumsq;
    logic [191:0] lhs;
    logic [191:0] rhs;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned t;
    sumsq = '0;
    for (int i = 0; i < 3; i++) sumsq += 192'(v[i] * v[i]);
    if (sumsq == 0) return;
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      q = 0;
      rhs = (192'(2 * mag) * 192'(2 * mag)) << (2 * FB);
      for (int b = FB; b >= 0; b--) begin
        t = q | (64'd1 << b);
        lhs = 192'(2 * t - 1) * 192'(2 * t - 1) * sumsq;
        if (t <= (64'd1 << FB) && lhs <= rhs) q = t;
      end
      v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic ofuf_pkg::out_t predict_frame(ofuf_pkg::in_t item);
    longint up[3], fw[3], rt[3], nu[3];
    ofuf_pkg::out_t f;
    up = '{longint'(item.up_in_x), longint'(item.up_in_y), longint'(item.up_in_z)};
    fw = '{longint'(item.fwd_in_x), longint'(item.fwd_in_y), longint'(item.fwd_in_z)};
    cross_fx(up, fw, rt);
    cross_fx(fw, rt, nu);
    if (item.do_normalize) begin
      unit_scale(rt);
      unit_scale(nu);
      unit_scale(fw);
    end
    f.right_x = rt[0][31:0];
    f.right_y = rt[1][31:0];
    f.right_z = rt[2][31:0];
    f.up_out_x = nu[0][31:0];
    f.up_out_y = nu[1][31:0];
    f.up_out_z = nu[2][31:0];
    f.fwd_out_x = fw[0][31:0];
    f.fwd_out_y = fw[1][31:0];
    f.fwd_out_z = fw[2][31:0];
    return f;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    ofuf_pkg::out_t exp_f;
    if (rst_ni && valid_o && !stall_i) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        $error("output beat with no frame expected");
        errors++;
      end else begin
        exp_f = expected_frames.pop_front();
        check_field("right_x", exp_f.right_x, data_o.right_x);
        check_field("right_y", exp_f.right_y, data_o.right_y);
        check_field("right_z", exp_f.right_z, data_o.right_z);
        check_field("up_out_x", exp_f.up_out_x, data_o.up_out_x);
        check_field("up_out_y", exp_f.up_out_y, data_o.up_out_y);
        check_field("up_out_z", exp_f.up_out_z, data_o.up_out_z);
        check_field("fwd_out_x", exp_f.fwd_out_x, data_o.fwd_out_x);
        check_field("fwd_out_y", exp_f.fwd_out_y, data_o.fwd_out_y);
        check_field("fwd_out_z", exp_f.fwd_out_z, data_o.fwd_out_z);
      end
    end
  end

  // Receiver: random stalls, a long counted hold-off on request, or no stalls in full-rate mode.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (out_idle_on) begin
      stall_i <= ($urandom_range(99) < 32);
    end else begin
      stall_i <= 1'b0;
    end
  end

  bit in_idle_on = 1'b1;

  task automatic send_item(ofuf_pkg::in_t item);
    while (in_idle_on && $urandom_range(99) < 32) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_i <= item;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_frames.push_back(predict_frame(item));
    items_sent++;
    if (item.do_normalize) normalized_sent++;
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(8192)) - 4096);
      3: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ofuf_pkg::in_t random_item();
    ofuf_pkg::in_t it;
    it.up_in_x = pick_comp();
    it.up_in_y = pick_comp();
    it.up_in_z = pick_comp();
    it.fwd_in_x = pick_comp();
    it.fwd_in_y = pick_comp();
    it.fwd_in_z = pick_comp();
    it.do_normalize = $urandom_range(1);
    if ($urandom_range(19) == 0) {it.up_in_x, it.up_in_y, it.up_in_z} = '0;
    if ($urandom_range(19) == 0) it.fwd_in_x = it.up_in_x;
    return it;
  endfunction

  task automatic test_directed();
    logic [15:0] vals[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000, 16'hf000, 16'hffff};
    ofuf_pkg::in_t it;
    for (int n = 0; n < 2; n++) begin
      send_item('{0, 0, 0, 0, 0, 0, n});
      send_item('{16'h1000, 0, 0, 0, 0, 16'h1000, n});
      send_item('{16'h1000, 16'h1000, 0, 16'h1000, 16'h1000, 0, n});
      send_item('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, n});
      send_item('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, n});
      send_item('{0, 0, 16'h0001, 16'h0001, 0, 0, n});
    end
    for (int i = 0; i < 6; i++) begin
      it = '{vals[i], vals[(i + 1) % 6], vals[(i + 2) % 6],
             vals[(i + 3) % 6], vals[(i + 4) % 6], vals[(i + 5) % 6], i[0]};
      send_item(it);
    end
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  task automatic test_full_rate();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random(150);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    in_idle_on = 1'b0;
    hold_cycles = 3 * LATENCY + 20;
    test_random(60);
    in_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    wait_drained();
    test_full_rate();
    test_backpressure();
    test_random(320);
    wait_drained();
    $display("Sent %0d beats (%0d normalized), checked %0d output frames.",
             items_sent, normalized_sent, frames_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
